### sv/vrao_pkg.sv
// package for the vector rotation angle offset unit
// types, constants and table functions shared by the cells and the top level
// no dependencies
package vrao_pkg;

  localparam int CORDIC_STAGES = 28;
  localparam int SQRT_STEPS    = 32;
  localparam int XY_W          = 62;
  localparam int ACC_W         = 34;
  localparam int IDX_W         = 6;
  // input regs, lzc, shift, two squares, sum, sqrt chain, select, lzc, shift, cordic, output
  localparam int LATENCY       = 6 + SQRT_STEPS + 3 + CORDIC_STAGES + 1;

  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [1:0] MODE_CHI = 2'd1;
  localparam logic [1:0] MODE_PSI = 2'd2;

  // per-item data that rides along the pipeline
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               psi;
    logic               y_zero;
    logic               x_pos;
    logic               z_neg;
    logic signed [30:0] euler;
    logic [31:0]        z_mag;
    logic [31:0]        m1_xv;
    logic signed [32:0] m1_yv;
  } side_t;

  // position of the highest set bit
  function automatic logic [IDX_W-1:0] msb_pos(input logic [32:0] v);
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) pos = IDX_W'(i);
    end
    return pos;
  endfunction

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ACC_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [ACC_W-1:0] r;
    unique case (i)
      6'd0:  r = 34'sh03243F6A8;
      6'd1:  r = 34'sh01DAC6705;
      6'd2:  r = 34'sh00FADBAFC;
      6'd3:  r = 34'sh007F56EA6;
      6'd4:  r = 34'sh003FEAB76;
      6'd5:  r = 34'sh001FFD55B;
      6'd6:  r = 34'sh000FFFAAA;
      6'd7:  r = 34'sh0007FFF55;
      6'd8:  r = 34'sh0003FFFEA;
      6'd9:  r = 34'sh0001FFFFD;
      6'd10: r = 34'sh0000FFFFF;
      default: begin
        if (i <= 6'd30) r = ACC_W'((64'd1 << (6'd30 - i)) - 64'd1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

### sv/vrao_sqrt_cell.sv
// one bit step of the restoring integer square root
// depends on vrao_pkg
module vrao_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           bit_idx_i,
  input  logic [63:0]          rem_i,
  input  logic [63:0]          res_i,
  input  vrao_pkg::side_t      side_i,
  output logic [63:0]          rem_o,
  output logic [63:0]          res_o,
  output vrao_pkg::side_t      side_o
);

  logic [63:0]     bit_w;
  logic [64:0]     trial;
  logic            take;
  logic [63:0]     rem_d, rem_q, res_d, res_q;
  vrao_pkg::side_t side_q;

  always_comb begin
    bit_w = 64'd1 << {bit_idx_i, 1'b0};
    trial = {1'b0, res_i} + {1'b0, bit_w};
    take  = {1'b0, rem_i} >= trial;
    rem_d = take ? rem_i - trial[63:0] : rem_i;
    res_d = take ? (res_i >> 1) + bit_w : (res_i >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign rem_o  = rem_q;
  assign res_o  = res_q;
  assign side_o = side_q;

endmodule

### sv/vrao_cordic_cell.sv
// one vectoring cordic micro-rotation with its angle accumulator
// depends on vrao_pkg
module vrao_cordic_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [vrao_pkg::IDX_W-1:0]           stage_i,
  input  logic signed [vrao_pkg::XY_W-1:0]     x_i,
  input  logic signed [vrao_pkg::XY_W-1:0]     y_i,
  input  logic signed [vrao_pkg::ACC_W-1:0]    acc_i,
  input  vrao_pkg::side_t                      side_i,
  output logic signed [vrao_pkg::XY_W-1:0]     x_o,
  output logic signed [vrao_pkg::XY_W-1:0]     y_o,
  output logic signed [vrao_pkg::ACC_W-1:0]    acc_o,
  output vrao_pkg::side_t                      side_o
);

  logic signed [vrao_pkg::XY_W-1:0]  dx, dy, x_d, x_q, y_d, y_q;
  logic signed [vrao_pkg::ACC_W-1:0] ang, acc_d, acc_q;
  vrao_pkg::side_t                   side_q;

  always_comb begin
    dx  = x_i >>> stage_i;
    dy  = y_i >>> stage_i;
    ang = vrao_pkg::atan_q30(stage_i);
    if (!y_i[vrao_pkg::XY_W-1]) begin
      x_d   = x_i + dy;
      y_d   = y_i - dx;
      acc_d = acc_i + ang;
    end else begin
      x_d   = x_i - dy;
      y_d   = y_i + dx;
      acc_d = acc_i - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign acc_o  = acc_q;
  assign side_o = side_q;

endmodule

### sv/vector_rotation_angle_offset_unit.sv
// top level of the vector rotation angle offset unit
// depends on vrao_pkg, vrao_sqrt_cell and vrao_cordic_cell
//
// channel   | direction | signals                                       | flow
// ----------+-----------+-----------------------------------------------+-------------
// command   | in        | start_i, busy_o, mode_i, euler_angle_i, vec_* | start & !busy
// result    | out       | valid_o, angle_out_o                          | one-cycle strobe
//
// one item enters per cycle; each item crosses the 32-cell square root row plus the
// 28-cell cordic row and the normalize, square and output stages around them
// busy_o is held low: the pipeline has no state between items
// reset clears the valid bits of every stage; the receiver cannot stall
module vector_rotation_angle_offset_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [30:0] euler_angle_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               valid_o,
  output logic signed [31:0] angle_out_o
);

  localparam int NS = vrao_pkg::SQRT_STEPS;
  localparam int NC = vrao_pkg::CORDIC_STAGES;
  localparam int XW = vrao_pkg::XY_W;
  localparam int AW = vrao_pkg::ACC_W;

  // ---------------- input stage: magnitudes and item flags
  vrao_pkg::side_t   side0_d, side0_q;
  logic [31:0]       ax0_d, ay0_d, ax0_q, ay0_q;
  logic [31:0]       az0;

  assign busy_o = 1'b0;

  always_comb begin
    ax0_d = vec_x_i[31] ? 32'(-vec_x_i) : 32'(vec_x_i);
    ay0_d = vec_y_i[31] ? 32'(-vec_y_i) : 32'(vec_y_i);
    az0   = vec_z_i[31] ? 32'(-vec_z_i) : 32'(vec_z_i);
    side0_d.valid  = start_i;
    side0_d.zero   = ((vec_x_i == '0) && (vec_y_i == '0)) ||
                     ((mode_i != vrao_pkg::MODE_CHI) && (mode_i != vrao_pkg::MODE_PSI));
    side0_d.psi    = (mode_i == vrao_pkg::MODE_PSI);
    side0_d.y_zero = (vec_y_i == '0);
    side0_d.x_pos  = !vec_x_i[31];
    side0_d.z_neg  = vec_z_i[31];
    side0_d.euler  = euler_angle_i;
    side0_d.z_mag  = az0;
    // chi: y > 0 gives atan2(-x, y), y < 0 gives atan2(x, -y)
    side0_d.m1_xv  = ay0_d;
    side0_d.m1_yv  = vec_y_i[31] ? 33'(vec_x_i) : -33'(vec_x_i);
  end

  // ---------------- psi front end: common normalize, squares, sum
  vrao_pkg::side_t side1_q, side2_d, side2_q, side3_q, side4_q, side5_q;
  logic [31:0]     ax1_q, ay1_q, ax2_q, ay2_q, ay3_q;
  logic [4:0]      sh1_q;
  logic [4:0]      sh1_d;
  logic [vrao_pkg::IDX_W-1:0] msb1;
  logic [63:0]     sqx3_q, sqx4_q, sqy4_q, n5_q;

  always_comb begin
    msb1  = vrao_pkg::msb_pos({1'b0, ax0_q | ay0_q | side0_q.z_mag});
    // bring the largest magnitude up to at least 2^30
    sh1_d = (msb1 >= 6'd30) ? 5'd0 : 5'(6'd30 - msb1);
  end

  // z magnitude takes the same shift as x and y
  always_comb begin
    side2_d       = side1_q;
    side2_d.z_mag = side1_q.z_mag << sh1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
    end else begin
      side0_q <= side0_d;
      side1_q <= side0_q;
      side2_q <= side2_d;
      side3_q <= side2_q;
      side4_q <= side3_q;
      side5_q <= side4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax0_q  <= ax0_d;
    ay0_q  <= ay0_d;
    ax1_q  <= ax0_q;
    ay1_q  <= ay0_q;
    sh1_q  <= sh1_d;
    ax2_q  <= ax1_q << sh1_q;
    ay2_q  <= ay1_q << sh1_q;
    sqx3_q <= 64'(ax2_q) * 64'(ax2_q);
    ay3_q  <= ay2_q;
    sqx4_q <= sqx3_q;
    sqy4_q <= 64'(ay3_q) * 64'(ay3_q);
    n5_q   <= sqx4_q + sqy4_q;
  end

  // ---------------- square root row, one result bit per cell
  logic [63:0]     sq_rem [NS+1];
  logic [63:0]     sq_res [NS+1];
  vrao_pkg::side_t sq_side[NS+1];

  assign sq_rem[0]  = n5_q;
  assign sq_res[0]  = '0;
  assign sq_side[0] = side5_q;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    vrao_sqrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bit_idx_i (5'(NS - 1 - k)),
      .rem_i     (sq_rem[k]),
      .res_i     (sq_res[k]),
      .side_i    (sq_side[k]),
      .rem_o     (sq_rem[k+1]),
      .res_o     (sq_res[k+1]),
      .side_o    (sq_side[k+1])
    );
  end

  // ---------------- cordic operand select and normalize
  vrao_pkg::side_t   side6_q, side7_q, side8_q;
  logic [31:0]       xv6_d, xv6_q, xv7_q;
  logic signed [32:0] yv6_d, yv6_q, yv7_q;
  logic [32:0]       m6_d, m6_q;
  logic [vrao_pkg::IDX_W-1:0] sh7_q;
  logic signed [XW-1:0] x8_q, y8_q;

  always_comb begin
    if (sq_side[NS].psi) begin
      xv6_d = sq_res[NS][31:0];
      yv6_d = sq_side[NS].z_neg ? -33'(sq_side[NS].z_mag) : 33'(sq_side[NS].z_mag);
    end else begin
      xv6_d = sq_side[NS].m1_xv;
      yv6_d = sq_side[NS].m1_yv;
    end
    m6_d = {1'b0, xv6_d} | (yv6_d[32] ? 33'(-yv6_d) : 33'(yv6_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side6_q <= '0;
      side7_q <= '0;
      side8_q <= '0;
    end else begin
      side6_q <= sq_side[NS];
      side7_q <= side6_q;
      side8_q <= side7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xv6_q <= xv6_d;
    yv6_q <= yv6_d;
    m6_q  <= m6_d;
    // larger magnitude lands in [2^58, 2^59)
    sh7_q <= vrao_pkg::IDX_W'(7'd58 - 7'(vrao_pkg::msb_pos(m6_q)));
    xv7_q <= xv6_q;
    yv7_q <= yv6_q;
    x8_q  <= XW'(xv7_q) << sh7_q;
    y8_q  <= XW'(yv7_q) <<< sh7_q;
  end

  // ---------------- cordic row
  logic signed [XW-1:0] cx  [NC+1];
  logic signed [XW-1:0] cy  [NC+1];
  logic signed [AW-1:0] cacc[NC+1];
  vrao_pkg::side_t      cside[NC+1];

  assign cx[0]    = x8_q;
  assign cy[0]    = y8_q;
  assign cacc[0]  = '0;
  assign cside[0] = side8_q;

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    vrao_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (vrao_pkg::IDX_W'(i)),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .acc_i   (cacc[i]),
      .side_i  (cside[i]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .acc_o   (cacc[i+1]),
      .side_o  (cside[i+1])
    );
  end

  // ---------------- angle select, round to q4.28, subtract euler
  vrao_pkg::side_t      fs;
  logic signed [AW:0]   ang, rnd;
  logic signed [31:0]   q28, res_d, res_q;
  logic                 valid_q;

  always_comb begin
    fs = cside[NC];
    if (fs.psi) begin
      ang = (AW+1)'(vrao_pkg::HALF_PI_Q30) - (AW+1)'(cacc[NC]);
    end else if (fs.y_zero) begin
      // chi on the x axis is exactly a quarter turn
      ang = fs.x_pos ? -(AW+1)'(vrao_pkg::HALF_PI_Q30) : (AW+1)'(vrao_pkg::HALF_PI_Q30);
    end else begin
      ang = (AW+1)'(cacc[NC]);
    end
    rnd   = ang + (AW+1)'(2);
    q28   = rnd[33:2];
    res_d = fs.zero ? '0 : (q28 - 32'(fs.euler));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= fs.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o     = valid_q;
  assign angle_out_o = res_q;

endmodule

### sv/vrao_checker.sv
// port-level checks for the vector rotation angle offset unit, bound to the top level
// depends on vrao_pkg
module vrao_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [1:0]         mode_i,
  input logic signed [31:0] vec_x_i,
  input logic signed [31:0] vec_y_i,
  input logic               valid_o,
  input logic signed [31:0] angle_out_o
);

  localparam int LAT = vrao_pkg::LATENCY;

  logic [6:0] age_q;
  logic       warm;
  logic       degen;

  assign warm  = (age_q == 7'(LAT));
  assign degen = ((mode_i != vrao_pkg::MODE_CHI) && (mode_i != vrao_pkg::MODE_PSI)) ||
                 ((vec_x_i == '0) && (vec_y_i == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (!warm) begin
      age_q <= age_q + 7'd1;
    end
  end

  // the pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // every accepted item gives exactly one strobe after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (valid_o == $past(start_i && !busy_o, LAT)))
    else $error("result strobe out of step with accepted items");

  // no strobe before the first item can have crossed the pipeline
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !warm |-> !valid_o)
    else $error("result strobe too early after reset");

  // unused mode or vector on the z axis gives zero
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && valid_o && $past(degen, LAT)) |-> (angle_out_o == '0))
    else $error("degenerate item gave nonzero angle");

endmodule

bind vector_rotation_angle_offset_unit vrao_checker u_vrao_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .mode_i      (mode_i),
  .vec_x_i     (vec_x_i),
  .vec_y_i     (vec_y_i),
  .valid_o     (valid_o),
  .angle_out_o (angle_out_o)
);
